>>> hw/rtl/dq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the double-ended queue: opcodes, status codes,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_LIST_FWD   = 3'd4,
    OP_LIST_REV   = 3'd5
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LIST = 3'b100
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // capture the accepted word
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic list_rd;     // read next listing entry
    logic emit_full;
    logic emit_empty;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            empty;
    logic            list_end;
  } stat_t;

endpackage : dq_pkg
`default_nettype wire

>>> hw/rtl/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque of signed 32-bit words in a ring store with front index and count.
// ----------------------------------------------------------------------------
// Push, full and empty results are written into the result register by the
// execute state; a pop result passes the registered store read first.
// A listing of N entries strobes N results on consecutive cycles.
// busy_o is high in the execute state and through a listing, and start_i
// is taken only when idle. Results cannot be stalled.
// Reset clears front index and count; store contents stay undefined, no sweep.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic        [OP_W-1:0]     operation_i,
  input  wire logic signed [DATA_W-1:0]   item_value_i,
  output logic                            result_valid_o,
  output logic signed      [DATA_W-1:0]   result_value_o,
  output logic             [STATUS_W-1:0] status_o,
  output logic                            last_o
);

  cmd_t  cmd;
  stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  dq_datapath #(
    .Depth (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operation_i    (operation_i),
    .item_value_i   (item_value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule : double_ended_queue
`default_nettype wire

>>> hw/rtl/dq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : dq_ram
`default_nettype wire

>>> hw/rtl/dq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Controller: takes a command word, decodes the opcode against the full and
// empty flags and steps a listing one entry per cycle.
// ----------------------------------------------------------------------------
module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  start_i,
  output logic       busy_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        unique case (opcode_e'(stat_i.op))
          OP_PUSH_FRONT: begin
            cmd_o.emit_full  = stat_i.full;
            cmd_o.push_front = !stat_i.full;
          end
          OP_PUSH_BACK: begin
            cmd_o.emit_full = stat_i.full;
            cmd_o.push_back = !stat_i.full;
          end
          OP_POP_FRONT: begin
            cmd_o.emit_empty = stat_i.empty;
            cmd_o.pop_front  = !stat_i.empty;
          end
          OP_POP_BACK: begin
            cmd_o.emit_empty = stat_i.empty;
            cmd_o.pop_back   = !stat_i.empty;
          end
          OP_LIST_FWD, OP_LIST_REV: begin
            cmd_o.emit_empty = stat_i.empty;
            cmd_o.list_rd    = !stat_i.empty;
            if (!stat_i.empty && !stat_i.list_end) begin
              state_d = S_LIST;
            end
          end
          default: ;  // unused opcodes are dropped
        endcase
      end
      S_LIST: begin
        cmd_o.list_rd = 1'b1;
        if (stat_i.list_end) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule : dq_ctrl
`default_nettype wire

>>> hw/rtl/dq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_datapath
// Ring pointers (front index, count), listing offset, entry store and the
// result register with its strobe.
// ----------------------------------------------------------------------------
module dq_datapath
  import dq_pkg::*;
#(
  parameter int Depth = DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic        [OP_W-1:0]     operation_i,
  input  wire logic signed [DATA_W-1:0]   item_value_i,
  input  wire cmd_t                       cmd_i,
  output stat_t                           stat_o,
  output logic                            result_valid_o,
  output logic signed      [DATA_W-1:0]   result_value_o,
  output logic             [STATUS_W-1:0] status_o,
  output logic                            last_o
);

  localparam int IdxW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int SumW = IdxW + 1;

  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] val_q;
  logic [IdxW-1:0]   front_q, front_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              pend_q, pend_last_q;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_value_q;
  logic [STATUS_W-1:0] out_status_q;
  logic              out_last_q;

  logic [IdxW-1:0]   cnt_m1, rd_off, wr_off, rd_pos, wr_pos, front_inc, front_dec;
  logic              full, empty, list_end, we, re;
  logic [DATA_W-1:0] rdata;

  // (base + off) mod Depth, both operands below Depth
  function automatic logic [IdxW-1:0] ring_add(logic [IdxW-1:0] base, logic [IdxW-1:0] off);
    logic [SumW-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SumW'(Depth)) begin
      sum = sum - SumW'(Depth);
    end
    return sum[IdxW-1:0];
  endfunction

  assign full      = (count_q == CntW'(Depth));
  assign empty     = (count_q == '0);
  assign cnt_m1    = count_q[IdxW-1:0] - IdxW'(1);
  assign list_end  = (idx_q == cnt_m1);
  assign front_inc = (front_q == IdxW'(Depth - 1)) ? '0 : front_q + IdxW'(1);
  assign front_dec = (front_q == '0) ? IdxW'(Depth - 1) : front_q - IdxW'(1);

  assign stat_o = '{op: op_q, full: full, empty: empty, list_end: list_end};

  always_comb begin
    if (cmd_i.pop_front) begin
      rd_off = '0;
    end else if (cmd_i.pop_back) begin
      rd_off = cnt_m1;
    end else if (opcode_e'(op_q) == OP_LIST_REV) begin
      rd_off = cnt_m1 - idx_q;
    end else begin
      rd_off = idx_q;
    end
  end

  // count < Depth on a push, so its low bits are the back offset
  assign wr_off = count_q[IdxW-1:0];
  assign rd_pos = ring_add(front_q, rd_off);
  assign wr_pos = cmd_i.push_front ? front_dec : ring_add(front_q, wr_off);
  assign we     = cmd_i.push_front | cmd_i.push_back;
  assign re     = cmd_i.pop_front | cmd_i.pop_back | cmd_i.list_rd;

  dq_ram #(
    .Width (DATA_W),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_pos),
    .wdata_i (val_q),
    .re_i    (re),
    .raddr_i (rd_pos),
    .rdata_o (rdata)
  );

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.load_in) begin
      idx_d = '0;
    end
    if (cmd_i.list_rd) begin
      idx_d = idx_q + IdxW'(1);
    end
    if (cmd_i.push_front) begin
      front_d = front_dec;
    end
    if (cmd_i.pop_front) begin
      front_d = front_inc;
    end
    if (we) begin
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.pop_front | cmd_i.pop_back) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pend_q      <= re;
      // a pop and the final listing read close the item
      pend_last_q <= cmd_i.pop_front | cmd_i.pop_back | list_end;
      out_valid_q <= pend_q | we | cmd_i.emit_full | cmd_i.emit_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= operation_i;
      val_q <= item_value_i;
    end
    if (pend_q) begin
      out_value_q  <= rdata;
      out_status_q <= ST_OK;
      out_last_q   <= pend_last_q;
    end else if (we) begin
      out_value_q  <= val_q;
      out_status_q <= ST_OK;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_full) begin
      out_value_q  <= '0;
      out_status_q <= ST_FULL;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_empty) begin
      out_value_q  <= '0;
      out_status_q <= ST_EMPTY;
      out_last_q   <= 1'b1;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

  // pending store read must never collide with a direct result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !(we || cmd_i.emit_full || cmd_i.emit_empty))
    else $error("result register collision");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CntW'(Depth)) && (front_q <= IdxW'(Depth - 1)))
    else $error("ring pointer out of range");

  // pushes only when not full, pops and listings only when not empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((we |-> !full) and (re |-> !empty)))
    else $error("store access against occupancy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_front || cmd_i.pop_back) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("pop did not shrink count");

endmodule : dq_datapath
`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for double_ended_queue. A directed table is walked first,
// and then random episodes that lean toward filling, draining or mixed traffic.
// Each result word is checked against its table row's expectation if given, else a deque predictor.
// ----------------------------------------------------------------------------
module tb_top
  import dq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH       = DEPTH_DEF;
  localparam int          RAND_WORDS  = 320;
  localparam int          CYCLE_LIMIT = 500_000;
  localparam int          TAIL_CYCLES = 8;
  localparam logic [2:0]  OP_SPARE_6  = 3'd6;
  localparam logic [2:0]  OP_SPARE_7  = 3'd7;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_e                  status;
    logic                     last;
  } result_word_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic                     typed;     // expectation given in the row
    logic signed [DATA_W-1:0] exp_value;
    status_e                  exp_status;
  } cmd_row_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [OP_W-1:0]          operation_i;
  logic signed [DATA_W-1:0] item_value_i;
  logic                     result_valid_o;
  logic signed [DATA_W-1:0] result_value_o;
  logic [STATUS_W-1:0]      status_o;
  logic                     last_o;

  double_ended_queue #(.DEPTH(DEPTH)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .item_value_i   (item_value_i),
    .result_valid_o (result_valid_o),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  // predictor copy of the deque
  logic signed [DATA_W-1:0] ring_words [DEPTH];
  int                       head_idx;
  int                       fill_cnt;

  result_word_t owed_words [$];
  result_word_t model_words [$];
  int           fail_cnt;
  int           cycle_cnt;
  cmd_row_t     cmd_rows [22];

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** double_ended_queue: FAILED **");
      $finish;
    end
  end

  // fills model_words with the words one command causes, and updates the deque
  task automatic model_command(input logic [OP_W-1:0] op,
                               input logic signed [DATA_W-1:0] val);
    int           off;
    result_word_t w;
    model_words.delete();
    w.status = ST_OK;
    w.last   = 1'b1;
    w.value  = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (fill_cnt >= DEPTH) begin
          w.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head_idx = (head_idx + DEPTH - 1) % DEPTH;
            ring_words[head_idx] = val;
          end else begin
            ring_words[(head_idx + fill_cnt) % DEPTH] = val;
          end
          fill_cnt++;
          w.value = val;
        end
        model_words.push_back(w);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (fill_cnt == 0) begin
          w.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          w.value  = ring_words[head_idx];
          head_idx = (head_idx + 1) % DEPTH;
          fill_cnt--;
        end else begin
          w.value = ring_words[(head_idx + fill_cnt - 1) % DEPTH];
          fill_cnt--;
        end
        model_words.push_back(w);
      end
      OP_LIST_FWD, OP_LIST_REV: begin
        if (fill_cnt == 0) begin
          w.status = ST_EMPTY;
          model_words.push_back(w);
        end else begin
          for (int i = 0; i < fill_cnt; i++) begin
            off     = (op == OP_LIST_FWD) ? i : fill_cnt - 1 - i;
            w.value = ring_words[(head_idx + off) % DEPTH];
            w.last  = (i == fill_cnt - 1);
            model_words.push_back(w);
          end
        end
      end
      default: ; // spare codes are ignored
    endcase
  endtask

  // one start handshake; the word is predicted at the edge that takes it
  task automatic send_word(input cmd_row_t row, input int gap);
    result_word_t w;
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i      <= 1'b1;
    operation_i  <= row.op;
    item_value_i <= row.value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    model_command(row.op, row.value);
    if (row.typed) begin
      w.value  = row.exp_value;
      w.status = row.exp_status;
      w.last   = 1'b1;
      owed_words.push_back(w);
    end else begin
      foreach (model_words[i]) owed_words.push_back(model_words[i]);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return -1;
      3:       return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input traffic_mode_e mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
    case (mode)
      MODE_FILL: begin
        if (roll < 85) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        if (roll < 93) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      MODE_DRAIN: begin
        if (roll < 85) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        if (roll < 93) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end
      default: begin
        if (roll < 48) return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        if (roll < 90) return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      end
    endcase
    return $urandom_range(0, 1) ? OP_LIST_FWD : OP_LIST_REV;
  endfunction

  always @(posedge clk_i) begin
    result_word_t due;
    if (rst_ni && result_valid_o) begin
      if (owed_words.size() == 0) begin
        $error("unexpected result word: value %0d status %0d last %0b",
               result_value_o, status_o, last_o);
        fail_cnt++;
      end else begin
        due = owed_words.pop_front();
        if (result_value_o !== due.value) begin
          $error("result_value: expected %0d, actual %0d", due.value, result_value_o);
          fail_cnt++;
        end
        if (status_o !== due.status) begin
          $error("status: expected %0d, actual %0d", due.status, status_o);
          fail_cnt++;
        end
        if (last_o !== due.last) begin
          $error("last: expected %0b, actual %0b", due.last, last_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    cmd_row_t      row;
    traffic_mode_e mode;
    int            sent;
    int            span;
    bit            no_gaps;

    rst_ni       = 1'b0;
    start_i      = 1'b0;
    operation_i  = '0;
    item_value_i = '0;
    fail_cnt     = 0;
    cycle_cnt    = 0;
    head_idx     = 0;
    fill_cnt     = 0;
    sent         = 0;

    // empty after reset, the extremes, wrap of the front index, spare codes
    cmd_rows = '{
      '{OP_POP_FRONT,  32'sd0,       1'b1, 32'sd0,       ST_EMPTY},
      '{OP_POP_BACK,   32'sd0,       1'b1, 32'sd0,       ST_EMPTY},
      '{OP_LIST_FWD,   -32'sd1,      1'b1, 32'sd0,       ST_EMPTY},
      '{OP_LIST_REV,   VAL_MAX,      1'b1, 32'sd0,       ST_EMPTY},
      '{OP_SPARE_6,    32'sd5,       1'b0, 32'sd0,       ST_OK},
      '{OP_PUSH_BACK,  VAL_MAX,      1'b1, VAL_MAX,      ST_OK},
      '{OP_PUSH_FRONT, VAL_MIN,      1'b1, VAL_MIN,      ST_OK},
      '{OP_PUSH_BACK,  32'sd0,       1'b1, 32'sd0,       ST_OK},
      '{OP_PUSH_FRONT, -32'sd1,      1'b1, -32'sd1,      ST_OK},
      '{OP_PUSH_BACK,  32'sh5A5AA5A5, 1'b1, 32'sh5A5AA5A5, ST_OK},
      '{OP_LIST_FWD,   32'sd0,       1'b0, 32'sd0,       ST_OK},
      '{OP_LIST_REV,   32'sd0,       1'b0, 32'sd0,       ST_OK},
      '{OP_SPARE_7,    -32'sd1,      1'b0, 32'sd0,       ST_OK},
      '{OP_POP_FRONT,  32'sd0,       1'b1, -32'sd1,      ST_OK},
      '{OP_POP_BACK,   32'sd0,       1'b1, 32'sh5A5AA5A5, ST_OK},
      '{OP_POP_FRONT,  32'sd0,       1'b1, VAL_MIN,      ST_OK},
      '{OP_POP_BACK,   32'sd0,       1'b1, 32'sd0,       ST_OK},
      '{OP_POP_FRONT,  32'sd0,       1'b1, VAL_MAX,      ST_OK},
      '{OP_POP_BACK,   32'sd0,       1'b1, 32'sd0,       ST_EMPTY},
      '{OP_PUSH_FRONT, 32'sd1,       1'b0, 32'sd0,       ST_OK},
      '{OP_LIST_REV,   32'sd0,       1'b0, 32'sd0,       ST_OK},
      '{OP_POP_BACK,   32'sd0,       1'b0, 32'sd0,       ST_OK}
    };

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (cmd_rows[i]) send_word(cmd_rows[i], $urandom_range(0, 3) == 0 ? 0 :
                                    $urandom_range(0, 19));

    // episodes of biased traffic; fill runs can be long enough to hit full
    while (sent < RAND_WORDS) begin
      mode    = traffic_mode_e'($urandom_range(0, 2));
      span    = (mode == MODE_MIXED) ? $urandom_range(10, 40) : $urandom_range(40, 100);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < span && sent < RAND_WORDS; k++) begin
        row.op    = pick_op(mode);
        row.value = pick_value();
        row.typed = 1'b0;
        row.exp_value  = '0;
        row.exp_status = ST_OK;
        send_word(row, no_gaps ? 0 : $urandom_range(0, 19));
        if (row.op != OP_SPARE_6 && row.op != OP_SPARE_7) sent++;
      end
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("** double_ended_queue: PASSED **");
    end else begin
      $display("** double_ended_queue: FAILED **");
    end
    $finish;
  end

endmodule
